// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ----- design/pfls_pkg.sv -----
package pfls_pkg;
  localparam int unsigned FlowEntriesDefault = 1024;
  localparam int unsigned CntW  = 48;
  localparam int unsigned ByteW = 64;
  localparam int unsigned TimeW = 64;
  localparam int unsigned FiuW  = 11;
  localparam int unsigned PctW  = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [FiuW-1:0]  FiuReset  = 11'd1024;
  localparam logic [TimeW-1:0] TimeReset = 64'd1000000000;
  localparam logic [6:0] Percent = 7'd100;

  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_AGG    = 2'd2,
    FUNC_FLUSH  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_FLOWS  = 2'd0,
    CFG_WINDOW = 2'd1,
    CFG_IDLE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_SWEEP,
    ST_SWLAST,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic rd;
    logic wr;
    logic sw_rd;
    logic acc;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic sw_last;
    logic div_busy;
  } sts_t;
endpackage

// ----- design/pfls_ram.sv -----
module pfls_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end
  assign rdata_o = rdata_q;
endmodule

// ----- design/pfls_div.sv -----
// Restoring divider, one quotient bit per cycle.
module pfls_div
  import pfls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        busy_o,
  output logic [63:0] quo_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [64:0] shr;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    shr    = {rem_q, quo_q[63]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shr >= {1'b0, den_q}) begin
        rem_d = 64'(shr - {1'b0, den_q});
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shr[63:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
endmodule

// ----- design/pfls_ctrl.sv -----
module pfls_ctrl
  import pfls_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  func_e func_i,
  input  logic  out_free_i,
  input  sts_t  sts_i,
  output logic  in_ready_o,
  output cmd_t  cmd_o
);
  `include "assert_macros.svh"
  state_e state_q, state_d;
  func_e  func_q;
  logic   acc_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      func_q  <= FUNC_RECORD;
    end else begin
      state_q <= state_d;
      if (acc_in) func_q <= func_i;
    end
  end

  assign acc_in = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (func_i inside {FUNC_AGG, FUNC_FLUSH}) begin
            state_d = ST_SWEEP;
          end else begin
            cmd_o.rd = 1'b1;
            state_d  = ST_RD;
          end
        end
      end
      ST_RD: begin
        if (func_q == FUNC_RECORD) begin
          cmd_o.wr = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_SWEEP: begin
        cmd_o.sw_rd = 1'b1;
        if (sts_i.sw_last) state_d = ST_SWLAST;
      end
      ST_SWLAST: begin
        cmd_o.acc = 1'b1;
        state_d   = ST_WR;
      end
      ST_WR: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!sts_i.div_busy) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `ASSERT_CLK(a_out_after_div, cmd_o.out_load |-> !sts_i.div_busy, "output while dividing")
  `ASSERT_NEVER(a_rd_wr, cmd_o.rd && cmd_o.wr, "read and write together")
  `ASSERT_CLK(a_clr_no_in, (state_q == ST_CLEAR) |-> !in_ready_o, "input during clear")
endmodule

// ----- design/pfls_dp.sv -----
// Flow table datapath. During sweeps the previous cycle's read is
// accumulated/flushed while the next entry is addressed.
module pfls_dp
  import pfls_pkg::*;
#(
  parameter int unsigned FlowEntries = FlowEntriesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic [1:0]       func_i,
  input  logic [15:0]      flow_i,
  input  logic [15:0]      bytes_i,
  input  logic             lost_i,
  input  logic [63:0]      time_i,
  input  logic [15:0]      service_i,
  input  logic [FiuW-1:0]  flows_in_use_i,
  input  logic [63:0]      window_i,
  input  logic [63:0]      idle_i,
  output logic [15:0]      echo_o,
  output logic [63:0]      pkt_o,
  output logic [63:0]      byte_o,
  output logic [PctW-1:0]  pct_o,
  output logic [FiuW-1:0]  flows_o,
  output logic [63:0]      begin_o,
  output logic             active_o
);
  localparam int unsigned AW = $clog2(FlowEntries);
  localparam int unsigned EW = CntW + ByteW + CntW + TimeW + 1;
  localparam int unsigned LimW = AW + 1;

  logic [AW:0]      clr_q;
  logic [AW-1:0]    raddr, waddr, sw_q, sw_prev_q;
  logic             we, sw_v_q;
  logic [EW-1:0]    wdata, rdata;
  logic [CntW-1:0]  r_pk, r_lo;
  logic [ByteW-1:0] r_by;
  logic [TimeW-1:0] r_tm;
  logic             r_ac;
  func_e            func_q;
  logic [15:0]      flow_q, bytes_q, svc_q;
  logic             lost_q, inr_q, empty_q;
  logic [63:0]      time_q, idle_q, beg_q;
  logic [LimW-1:0]  lim_q, lim;
  logic [63:0]      pk_q, by_q, lo_q;
  logic [FiuW-1:0]  fl_q;
  logic             div_busy, ac_q;
  logic [63:0]      div_q, num, den;
  logic             hit_win, hit_idle;

  assign lim = (32'(flows_in_use_i) > FlowEntries) ? LimW'(FlowEntries)
               : LimW'(flows_in_use_i);

  assign {r_pk, r_by, r_lo, r_tm, r_ac} = rdata;

  pfls_ram #(.Width(EW), .Depth(FlowEntries)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign raddr = cmd_i.load ? flow_i[AW-1:0] : (cmd_i.sw_rd ? sw_q : flow_q[AW-1:0]);
  assign hit_win  = r_tm >= beg_q;
  assign hit_idle = (time_q - r_tm) > idle_q;

  always_comb begin
    we    = 1'b0;
    waddr = flow_q[AW-1:0];
    wdata = {CntW'(r_pk + 1'b1), ByteW'(r_by + {48'd0, bytes_q}),
             CntW'(r_lo + {{(CntW-1){1'b0}}, lost_q}), time_q, 1'b1};
    if (cmd_i.clr_wr) begin
      we = 1'b1; waddr = clr_q[AW-1:0]; wdata = '0;
    end else if (cmd_i.wr) begin
      we = inr_q;
    end else if (sw_v_q && func_q == FUNC_FLUSH && hit_idle) begin
      we = 1'b1; waddr = sw_prev_q; wdata = {rdata[EW-1:1], 1'b0};
    end
  end

  // a flow query divides the entry just read; sweeps divide the sums
  assign num = (func_q == FUNC_QUERY) ? (inr_q ? 64'(64'(r_lo) * 64'd100) : '0)
               : 64'(lo_q * 64'd100);
  assign den = (func_q == FUNC_QUERY) ? (inr_q ? 64'(r_pk) : '0) : pk_q;
  pfls_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(num), .den_i(den),
    .busy_o(div_busy), .quo_o(div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      sw_v_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + 1'b1;
      sw_v_q <= cmd_i.sw_rd && ({1'b0, sw_q} < lim_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_e'(func_i);
      flow_q  <= flow_i;
      bytes_q <= bytes_i;
      lost_q  <= lost_i;
      time_q  <= time_i;
      svc_q   <= service_i;
      lim_q   <= lim;
      inr_q   <= {1'b0, flow_i} < 17'(lim);
      beg_q   <= time_i - window_i;
      idle_q  <= idle_i;
      sw_q    <= '0;
      pk_q <= '0; by_q <= '0; lo_q <= '0; fl_q <= '0; ac_q <= 1'b0;
      empty_q <= (lim == '0);
    end else begin
      if (cmd_i.sw_rd) begin
        sw_prev_q <= sw_q;
        sw_q      <= sw_q + 1'b1;
      end
      if (sw_v_q && ((func_q == FUNC_AGG && hit_win) ||
                     (func_q == FUNC_FLUSH && hit_idle))) begin
        fl_q <= fl_q + 1'b1;
        if (func_q == FUNC_AGG) begin
          pk_q <= pk_q + 64'(r_pk);
          by_q <= by_q + r_by;
          lo_q <= lo_q + 64'(r_lo);
        end
      end
      if (cmd_i.div_start && func_q == FUNC_QUERY) begin
        pk_q <= inr_q ? 64'(r_pk) : '0;
        by_q <= inr_q ? r_by : '0;
        lo_q <= inr_q ? 64'(r_lo) : '0;
        ac_q <= inr_q & r_ac;
      end
    end
  end

  assign sts_o.clr_done = (clr_q == (AW+1)'(FlowEntries - 1));
  assign sts_o.sw_last  = empty_q || ({1'b0, sw_q} == lim_q - 1'b1) ||
                          (sw_q == AW'(FlowEntries - 1));
  assign sts_o.div_busy = div_busy || cmd_i.div_start;

  always_comb begin
    echo_o = '0; pkt_o = '0; byte_o = '0; pct_o = '0;
    flows_o = '0; begin_o = '0; active_o = 1'b0;
    case (func_q)
      FUNC_QUERY: begin
        echo_o = flow_q; pkt_o = pk_q; byte_o = by_q; active_o = ac_q;
        pct_o = (pk_q == '0) ? '0 : (div_q > 64'd100 ? Percent : div_q[PctW-1:0]);
      end
      FUNC_AGG: begin
        echo_o = svc_q; pkt_o = pk_q; byte_o = by_q; flows_o = fl_q; begin_o = beg_q;
        pct_o = (pk_q == '0) ? '0 : (div_q > 64'd100 ? Percent : div_q[PctW-1:0]);
      end
      FUNC_FLUSH: flows_o = fl_q;
      default: ;
    endcase
  end
endmodule

// ----- design/per_flow_loss_statistics_table_unit.sv -----
// Per-flow statistics table. After reset a clearing pass over all
// FLOW_ENTRIES entries zeroes the table; no request is taken meanwhile.
// A record reads its entry and then writes it (one table RAM port pair);
// a flow query reads its entry and then runs the bit-serial loss-percent
// divider. Aggregate and flush requests sweep the flows in use (at most
// FLOW_ENTRIES) at one entry per cycle and then divide. Results leave
// through an output register; a held result stalls the next query,
// aggregate or flush at its output load, and all requests behind it.
module per_flow_loss_statistics_table_unit
  import pfls_pkg::*;
#(
  parameter int unsigned FLOW_ENTRIES = FlowEntriesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [63:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // func[1:0], flow_number[17:2], packet_bytes[33:18], lost_mark[34],
  // current_time[98:35], service_number[114:99], zero fill
  input  logic [119:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // echo_id[15:0], packet_total[79:16], byte_total[143:80],
  // loss_pct[150:144], flow_total[161:151], window_begin[225:162],
  // flow_active[226], zero fill
  output logic [231:0]  m_axis_tdata
);
  `include "assert_macros.svh"
  logic [FiuW-1:0] fiu_q;
  logic [63:0]     win_q, idle_q;
  cmd_t            cmd;
  sts_t            sts;
  logic            ovalid_q, out_free;
  logic [231:0]    odata_q, res;
  logic [15:0]     echo;
  logic [63:0]     pkt, byt, beg;
  logic [PctW-1:0] pct;
  logic [FiuW-1:0] fls;
  logic            act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q  <= FiuReset;
      win_q  <= TimeReset;
      idle_q <= TimeReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FLOWS:  fiu_q  <= cfg_data_i[FiuW-1:0];
        CFG_WINDOW: win_q  <= cfg_data_i;
        CFG_IDLE:   idle_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free = !ovalid_q || m_axis_tready;

  pfls_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .func_i(func_e'(s_axis_tdata[1:0])),
    .out_free_i(out_free), .sts_i(sts), .in_ready_o(s_axis_tready), .cmd_o(cmd)
  );

  pfls_dp #(.FlowEntries(FLOW_ENTRIES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .func_i(s_axis_tdata[1:0]), .flow_i(s_axis_tdata[17:2]),
    .bytes_i(s_axis_tdata[33:18]), .lost_i(s_axis_tdata[34]),
    .time_i(s_axis_tdata[98:35]), .service_i(s_axis_tdata[114:99]),
    .flows_in_use_i(fiu_q), .window_i(win_q), .idle_i(idle_q),
    .echo_o(echo), .pkt_o(pkt), .byte_o(byt), .pct_o(pct),
    .flows_o(fls), .begin_o(beg), .active_o(act)
  );

  assign res = {5'd0, act, beg, fls, pct, byt, pkt, echo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (cmd.out_load) ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) odata_q <= res;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  `ASSERT_CLK(a_hold, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "unstable")
  `ASSERT_CLK(a_load_free, cmd.out_load |-> out_free, "overwrite of pending result")
  `ASSERT_NEVER(a_pct, m_axis_tvalid && m_axis_tdata[150:144] > 7'd100, "percent range")
endmodule

// ----- dv/flow_stats_checker.sv -----
module flow_stats_checker
  import pfls_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [231:0] m_axis_tdata,
  output int           errors_o,
  output int           pending_o
);
  localparam int unsigned Entries = FlowEntriesDefault;

  typedef struct packed {
    logic [15:0] echo_id;
    logic [63:0] packet_total;
    logic [63:0] byte_total;
    logic [6:0]  pct_value;
    logic [10:0] flow_total;
    logic [63:0] window_begin;
    logic        flow_active;
  } stats_result_t;

  logic [47:0] pkt_cnt [Entries];
  logic [63:0] byte_cnt [Entries];
  logic [47:0] loss_cnt [Entries];
  logic [63:0] stamp [Entries];
  logic        active [Entries];

  logic [10:0] flows_in_use;
  logic [63:0] window_len;
  logic [63:0] idle_limit;

  stats_result_t pending_results[$];

  assign pending_o = pending_results.size();

  function automatic logic [6:0] loss_pct(logic [63:0] loss, logic [63:0] pkts);
    logic [63:0] q;
    if (pkts == 0) return 7'd0;
    q = (loss * 64'd100) / pkts;
    return (q > 64'd100) ? 7'd100 : q[6:0];
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch in %s: got %0h, want %0h", field, got, want);
    errors_o++;
  endtask

  task automatic apply_request(logic [119:0] d);
    func_e         fn;
    logic [15:0]   flow;
    logic [15:0]   nbytes;
    logic          lost;
    logic [63:0]   now;
    logic [15:0]   service;
    int            lim;
    stats_result_t r;
    logic [63:0]   lo;
    fn      = func_e'(d[1:0]);
    flow    = d[17:2];
    nbytes  = d[33:18];
    lost    = d[34];
    now     = d[98:35];
    service = d[114:99];
    lim     = (flows_in_use > Entries) ? Entries : flows_in_use;
    r       = '0;
    lo      = 0;
    case (fn)
      FUNC_RECORD: begin
        if (flow < lim) begin
          pkt_cnt[flow]  = pkt_cnt[flow] + 1;
          byte_cnt[flow] = byte_cnt[flow] + nbytes;
          if (lost) loss_cnt[flow] = loss_cnt[flow] + 1;
          stamp[flow]  = now;
          active[flow] = 1'b1;
        end
        return;
      end
      FUNC_QUERY: begin
        r.echo_id = flow;
        if (flow < lim) begin
          r.packet_total = pkt_cnt[flow];
          r.byte_total   = byte_cnt[flow];
          r.pct_value    = loss_pct(loss_cnt[flow], pkt_cnt[flow]);
          r.flow_active  = active[flow];
        end
      end
      FUNC_AGG: begin
        r.echo_id      = service;
        r.window_begin = now - window_len;
        for (int i = 0; i < lim; i++) begin
          if (stamp[i] >= r.window_begin) begin
            r.flow_total++;
            r.packet_total += pkt_cnt[i];
            r.byte_total   += byte_cnt[i];
            lo             += loss_cnt[i];
          end
        end
        r.pct_value = loss_pct(lo, r.packet_total);
      end
      default: begin
        for (int i = 0; i < lim; i++) begin
          if (now - stamp[i] > idle_limit) begin
            active[i] = 1'b0;
            r.flow_total++;
          end
        end
      end
    endcase
    pending_results = {pending_results, r};
  endtask

  task automatic check_result(logic [231:0] d);
    stats_result_t w;
    if (pending_results.size() == 0) begin
      report("unexpected result", d[63:0], 64'd0);
      return;
    end
    w = pending_results.pop_front();
    if (d[15:0] != w.echo_id) report("echo_id", d[15:0], w.echo_id);
    if (d[79:16] != w.packet_total) report("packet_total", d[79:16], w.packet_total);
    if (d[143:80] != w.byte_total) report("byte_total", d[143:80], w.byte_total);
    if (d[150:144] != w.pct_value) report("loss pct", d[150:144], w.pct_value);
    if (d[161:151] != w.flow_total) report("flow_total", d[161:151], w.flow_total);
    if (d[225:162] != w.window_begin) report("window_begin", d[225:162], w.window_begin);
    if (d[226] != w.flow_active) report("flow_active", d[226], w.flow_active);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      errors_o     = 0;
      flows_in_use = FiuReset;
      window_len   = TimeReset;
      idle_limit   = TimeReset;
      pending_results.delete();
      for (int i = 0; i < Entries; i++) begin
        pkt_cnt[i] = 0; byte_cnt[i] = 0; loss_cnt[i] = 0; stamp[i] = 0; active[i] = 0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_FLOWS:  flows_in_use = cfg_data_i[10:0];
          CFG_WINDOW: window_len   = cfg_data_i;
          CFG_IDLE:   idle_limit   = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) apply_request(s_axis_tdata);
    end
  end
endmodule

// ----- dv/testbench.sv -----
module testbench;
  import pfls_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [63:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [231:0] m_axis_tdata;
  int           errors;
  int           pending;

  int          snd_idle;
  int          rcv_idle;
  bit          hold_go;
  int          flows_cfg;
  logic [63:0] clock_ns;

  per_flow_loss_statistics_table_unit DUT (.*);

  flow_stats_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus one long hold-off on demand
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        m_axis_tready <= !(rcv_idle > 0 && $urandom_range(99) < rcv_idle);
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic [119:0] pack(func_e fn, logic [15:0] flow, logic [15:0] nbytes,
                                        logic lost, logic [63:0] now, logic [15:0] svc);
    return {5'b0, svc, now, lost, nbytes, flow, fn};
  endfunction

  task automatic push(logic [119:0] d);
    if (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic set_regs(int flows, logic [63:0] win, logic [63:0] idle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_FLOWS; cfg_data_i <= 64'(flows);
    @(posedge clk_i);
    cfg_idx_i <= CFG_WINDOW; cfg_data_i <= win;
    @(posedge clk_i);
    cfg_idx_i <= CFG_IDLE; cfg_data_i <= idle;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    flows_cfg = flows;
  endtask

  task automatic random_item();
    int          pick;
    func_e       fn;
    logic [15:0] flow;
    logic [63:0] now;
    pick = $urandom_range(99);
    fn = (pick < 60) ? FUNC_RECORD : (pick < 85) ? FUNC_QUERY :
         (pick < 93) ? FUNC_AGG : FUNC_FLUSH;
    flow = ($urandom_range(99) < 85) ? 16'($urandom_range(0, flows_cfg + 1))
                                     : 16'($urandom);
    clock_ns += $urandom_range(0, 300);
    now = ($urandom_range(99) < 15) ? {$urandom, $urandom} : clock_ns;
    push(pack(fn, flow, 16'($urandom), 1'($urandom), now, 16'($urandom)));
  endtask

  task automatic run_phase(int n, int s_idle, int r_idle);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    for (int i = 0; i < n; i++) random_item();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_FLOWS;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    snd_idle      = 0;
    rcv_idle      = 0;
    hold_go       = 1'b0;
    flows_cfg     = 1024;
    clock_ns      = 64'd5000;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, out-of-range flows, every function
    push(pack(FUNC_QUERY, 16'd0, 16'd0, 1'b0, 64'd0, 16'd0));
    push(pack(FUNC_RECORD, 16'd0, 16'hffff, 1'b1, 64'd100, 16'd0));
    push(pack(FUNC_RECORD, 16'd0, 16'd0, 1'b0, 64'd200, 16'hffff));
    push(pack(FUNC_RECORD, 16'd1023, 16'hffff, 1'b1, '1, 16'd0));
    push(pack(FUNC_RECORD, 16'd1024, 16'd5, 1'b1, 64'd300, 16'd0));
    push(pack(FUNC_RECORD, 16'hffff, 16'd5, 1'b0, 64'd300, 16'd0));
    push(pack(FUNC_QUERY, 16'd0, 16'd0, 1'b0, 64'd0, 16'd0));
    push(pack(FUNC_QUERY, 16'd1023, 16'hffff, 1'b1, 64'd0, 16'hffff));
    push(pack(FUNC_QUERY, 16'd1024, 16'd0, 1'b0, 64'd0, 16'd0));
    push(pack(FUNC_QUERY, 16'hffff, 16'd0, 1'b0, 64'd0, 16'd0));
    push(pack(FUNC_AGG, 16'd0, 16'd0, 1'b0, 64'd500, 16'hffff));
    push(pack(FUNC_AGG, 16'd0, 16'd0, 1'b0, '1, 16'd0));
    push(pack(FUNC_FLUSH, 16'd0, 16'd0, 1'b0, 64'd500, 16'd0));
    push(pack(FUNC_FLUSH, 16'd0, 16'd0, 1'b0, '1, 16'd0));
    push(pack(FUNC_QUERY, 16'd1023, 16'd0, 1'b0, 64'd0, 16'd0));

    set_regs(16, 64'd1000, 64'd500);
    push(pack(FUNC_RECORD, 16'd15, 16'd7, 1'b1, 64'd10, 16'd0));
    push(pack(FUNC_RECORD, 16'd16, 16'd7, 1'b1, 64'd10, 16'd0));
    push(pack(FUNC_QUERY, 16'd16, 16'd0, 1'b0, 64'd0, 16'd0));
    // long receiver hold-off while queries keep arriving
    hold_go = 1'b1;
    for (int i = 0; i < 12; i++) push(pack(FUNC_QUERY, 16'(i), 16'd0, 1'b0, 64'd0, 16'd0));
    run_phase(600, 28, 65);

    set_regs(1, 64'd0, '1);
    run_phase(300, 65, 28);
    set_regs(5, 64'd400, 64'd0);
    run_phase(300, 65, 28);

    set_regs(1024, '1, 64'd0);
    run_phase(300, 0, 0);
    set_regs(1024, {$urandom, $urandom}, 64'd2000);
    run_phase(300, 0, 0);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
